FILE: sv/dpbm_pkg.sv
// Shared constants, operation codes and types of the decoded picture buffer manager.
`timescale 1ns / 1ps
`default_nettype none
package dpbm_pkg;

  localparam int OP_W        = 4;
  localparam int IN_HDL_W    = 8;
  localparam int OUT_HDL_W   = 8;
  localparam int POC_W       = 32;
  localparam int LOW_W       = 16;
  localparam int OUT_CNT_W   = 5;
  localparam int ST_W        = 2;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;
  localparam int MAX_RESULTS = 16;
  localparam int LIST_CNT_W  = $clog2(MAX_RESULTS + 1);

  localparam logic [OP_W-1:0] OP_ADD        = 4'd0;
  localparam logic [OP_W-1:0] OP_CLEAR      = 4'd1;
  localparam logic [OP_W-1:0] OP_DEL_UNUSED = 4'd2;
  localparam logic [OP_W-1:0] OP_DEL_POC    = 4'd3;
  localparam logic [OP_W-1:0] OP_COUNT_REF  = 4'd4;
  localparam logic [OP_W-1:0] OP_UNMARK     = 4'd5;
  localparam logic [OP_W-1:0] OP_FIND_REF   = 4'd6;
  localparam logic [OP_W-1:0] OP_FIND_LOW   = 4'd7;
  localparam logic [OP_W-1:0] OP_FIND_SHORT = 4'd8;
  localparam logic [OP_W-1:0] OP_FIND_LONG  = 4'd9;
  localparam logic [OP_W-1:0] OP_LIST       = 4'd10;
  localparam logic [OP_W-1:0] OP_UPDATE     = 4'd11;
  localparam logic [OP_W-1:0] OP_STATUS     = 4'd12;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_DROPPED   = 2'd2;

  localparam logic             REG_MAX_PIC   = 1'b0;
  localparam logic [OUT_CNT_W-1:0] MAX_PIC_RESET = 5'd16;

  typedef struct packed {
    logic ref_f;
    logic lterm;
    logic done;
  } flags_t;

  typedef struct packed {
    logic poc_eq;
    logic low_eq;
    logic hdl_eq;
  } match_t;

  typedef struct packed {
    logic                   found;
    logic [OUT_HDL_W-1:0]   found_handle;
    logic [POC_W-1:0]       found_order_count;
    logic [OUT_CNT_W-1:0]   entry_count;
    logic [OUT_CNT_W-1:0]   reference_count;
    logic                   is_full;
    logic [ST_W-1:0]        status;
    logic                   last;
  } result_t;

endpackage
`default_nettype wire

FILE: sv/dpbm_ifs.sv
// Request and result channel interfaces of the decoded picture buffer manager.
`timescale 1ns / 1ps
`default_nettype none
interface dpbm_in_if;
  import dpbm_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic [IN_HDL_W-1:0]     picture_handle;
  logic signed [POC_W-1:0] order_count;
  logic [LOW_W-1:0]        order_count_low;
  logic                    is_reference;
  logic                    is_long_term;
  logic                    is_output_done;

  modport source(output valid, operation, picture_handle, order_count, order_count_low,
                 is_reference, is_long_term, is_output_done, input ready);
  modport sink(input valid, operation, picture_handle, order_count, order_count_low,
               is_reference, is_long_term, is_output_done, output ready);
endinterface

interface dpbm_out_if;
  import dpbm_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    found;
  logic [OUT_HDL_W-1:0]    found_handle;
  logic signed [POC_W-1:0] found_order_count;
  logic [OUT_CNT_W-1:0]    entry_count;
  logic [OUT_CNT_W-1:0]    reference_count;
  logic                    is_full;
  logic [ST_W-1:0]         status;
  logic                    last;

  modport source(output valid, found, found_handle, found_order_count, entry_count,
                 reference_count, is_full, status, last, input ready);
  modport sink(input valid, found, found_handle, found_order_count, entry_count,
               reference_count, is_full, status, last, output ready);
endinterface
`default_nettype wire

FILE: sv/dpbm_store.sv
// Picture entry memory with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module dpbm_store #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 59
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

FILE: sv/dpbm_match.sv
// Shared compare unit that matches one stored entry against the request key.
`timescale 1ns / 1ps
`default_nettype none
module dpbm_match #(
  parameter int HANDLE_WIDTH = 8
) (
  input  logic [HANDLE_WIDTH-1:0]     ent_hdl,
  input  logic [dpbm_pkg::POC_W-1:0]  ent_poc,
  input  logic [dpbm_pkg::LOW_W-1:0]  ent_low,
  input  logic [HANDLE_WIDTH-1:0]     key_hdl,
  input  logic [dpbm_pkg::POC_W-1:0]  key_poc,
  input  logic [dpbm_pkg::LOW_W-1:0]  key_low,
  output dpbm_pkg::match_t            match_o
);
  import dpbm_pkg::*;

  assign match_o.poc_eq = (ent_poc == key_poc);
  assign match_o.low_eq = (ent_low == key_low);
  assign match_o.hdl_eq = (ent_hdl == key_hdl);

endmodule
`default_nettype wire

FILE: sv/dpbm_result_reg.sv
// Output register that holds one result until the sink takes it.
`timescale 1ns / 1ps
`default_nettype none
module dpbm_result_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  dpbm_pkg::result_t res,
  output logic              free,
  dpbm_out_if.source        out_chan
);
  import dpbm_pkg::*;

  logic    valid_r;
  result_t res_r;

  assign free = !valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      res_r <= res;
    end
  end

  assign out_chan.valid             = valid_r;
  assign out_chan.found             = res_r.found;
  assign out_chan.found_handle      = res_r.found_handle;
  assign out_chan.found_order_count = res_r.found_order_count;
  assign out_chan.entry_count       = res_r.entry_count;
  assign out_chan.reference_count   = res_r.reference_count;
  assign out_chan.is_full           = res_r.is_full;
  assign out_chan.status            = res_r.status;
  assign out_chan.last              = res_r.last;

endmodule
`default_nettype wire

FILE: sv/decoded_picture_buffer_manager_unit.sv
// Top level of the decoded picture buffer manager: sequencer, store, compare unit, output.
// Sequencing: add, clear, count and status requests go straight to the final state S_FIN,
// which registers the result once the output is free; walking requests visit each held picture
// in a read state (S_RD) and then a compare state (S_EV) on the store's registered read port.
// Throughput: one request at a time; the next is taken once the final result is registered.
// Reset: synchronous active-low rst_n clears the count, sequencer and output; max_pictures=16.
`timescale 1ns / 1ps
`default_nettype none
module decoded_picture_buffer_manager_unit #(
  parameter int DEPTH        = 16,
  parameter int HANDLE_WIDTH = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  dpbm_in_if.sink                             in_chan,
  dpbm_out_if.source                          out_chan,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dpbm_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [dpbm_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [dpbm_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import dpbm_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = HANDLE_WIDTH + POC_W + LOW_W + 3;

  typedef struct packed {
    logic [HANDLE_WIDTH-1:0] hdl;
    logic [POC_W-1:0]        poc;
    logic [LOW_W-1:0]        low;
    flags_t                  flags;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_EV   = 4'b0100,
    S_FIN  = 4'b1000
  } seq_state_t;

  seq_state_t              state_r, state_nxt;
  logic [OP_W-1:0]         op_r;
  entry_t                  key_r;
  logic [CW-1:0]           idx_r, idx_nxt;
  logic [CW-1:0]           wr_idx_r, wr_idx_nxt;
  logic [CW-1:0]           held_r, held_nxt;
  logic [CW-1:0]           refs_r, refs_nxt;
  logic                    hit_r, hit_nxt;
  logic [LIST_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                    res_found_r, res_found_nxt;
  logic [HANDLE_WIDTH-1:0] res_hdl_r, res_hdl_nxt;
  logic [POC_W-1:0]        res_poc_r, res_poc_nxt;
  logic [ST_W-1:0]         status_r, status_nxt;
  logic [OUT_CNT_W-1:0]    max_pic_r;

  logic                    in_acc;
  logic [HANDLE_WIDTH+IN_HDL_W-1:0] in_hdl_ext;
  entry_t                  in_entry;
  entry_t                  ent;
  logic [EW-1:0]           rd_data;
  logic                    mem_wr_en, mem_rd_en;
  logic [IW-1:0]           mem_wr_addr;
  entry_t                  mem_wr_data;
  match_t                  m;
  logic                    push, out_free;
  result_t                 res;
  logic [HANDLE_WIDTH+OUT_HDL_W-1:0] res_hdl_ext;
  logic [CW+OUT_CNT_W-1:0] held_ext, refs_ext, max_ext;
  logic                    find_hit, drop;
  logic [ST_W-1:0]         end_status;
  logic                    cfg_wr;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;

  assign in_hdl_ext     = {{HANDLE_WIDTH{1'b0}}, in_chan.picture_handle};
  assign in_entry.hdl   = in_hdl_ext[HANDLE_WIDTH-1:0];
  assign in_entry.poc   = in_chan.order_count;
  assign in_entry.low   = in_chan.order_count_low;
  assign in_entry.flags = '{ref_f: in_chan.is_reference, lterm: in_chan.is_long_term,
                            done: in_chan.is_output_done};

  assign ent = rd_data;

  dpbm_store #(.DEPTH(DEPTH), .WIDTH(EW)) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (idx_r[IW-1:0]),
    .rd_data (rd_data)
  );

  dpbm_match #(.HANDLE_WIDTH(HANDLE_WIDTH)) u_match (
    .ent_hdl (ent.hdl),
    .ent_poc (ent.poc),
    .ent_low (ent.low),
    .key_hdl (key_r.hdl),
    .key_poc (key_r.poc),
    .key_low (key_r.low),
    .match_o (m)
  );

  always_comb begin
    find_hit = 1'b0;
    unique case (op_r) inside
      OP_FIND_LOW:   find_hit = m.low_eq;
      OP_FIND_SHORT: find_hit = m.poc_eq && !ent.flags.lterm;
      OP_FIND_LONG:  find_hit = m.poc_eq && ent.flags.lterm;
      default:       find_hit = m.poc_eq;
    endcase
    find_hit = find_hit && ent.flags.ref_f;
    drop = (op_r == OP_DEL_UNUSED) ? (ent.flags.done && !ent.flags.ref_f)
                                   : (m.poc_eq && !hit_r);
  end

  always_comb begin
    unique case (op_r) inside
      OP_DEL_POC, OP_UPDATE:                               end_status = hit_r ? ST_OK : ST_NOT_FOUND;
      OP_FIND_REF, OP_FIND_LOW, OP_FIND_SHORT, OP_FIND_LONG: end_status = ST_NOT_FOUND;
      OP_LIST:                                             end_status = (cnt_r == '0) ? ST_NOT_FOUND : ST_OK;
      default:                                             end_status = ST_OK;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    wr_idx_nxt    = wr_idx_r;
    held_nxt      = held_r;
    refs_nxt      = refs_r;
    hit_nxt       = hit_r;
    cnt_nxt       = cnt_r;
    res_found_nxt = res_found_r;
    res_hdl_nxt   = res_hdl_r;
    res_poc_nxt   = res_poc_r;
    status_nxt    = status_r;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = held_r[IW-1:0];
    mem_wr_data   = in_entry;
    mem_rd_en     = 1'b0;
    push          = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          idx_nxt       = '0;
          wr_idx_nxt    = '0;
          hit_nxt       = 1'b0;
          cnt_nxt       = '0;
          res_found_nxt = 1'b0;
          status_nxt    = ST_OK;
          state_nxt     = S_FIN;
          unique case (in_chan.operation) inside
            OP_ADD: begin
              if (held_r == CW'(DEPTH)) begin
                status_nxt = ST_DROPPED;
              end else begin
                mem_wr_en = 1'b1;
                held_nxt  = held_r + 1'b1;
                refs_nxt  = refs_r + CW'(in_chan.is_reference);
              end
            end
            OP_CLEAR: begin
              held_nxt = '0;
              refs_nxt = '0;
            end
            OP_DEL_UNUSED, OP_DEL_POC, OP_UNMARK, OP_FIND_REF, OP_FIND_LOW,
            OP_FIND_SHORT, OP_FIND_LONG, OP_LIST, OP_UPDATE: begin
              state_nxt = S_RD;
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_RD: begin
        if (idx_r == held_r) begin
          status_nxt = end_status;
          state_nxt  = S_FIN;
          if (op_r == OP_DEL_UNUSED || op_r == OP_DEL_POC) begin
            held_nxt = wr_idx_r;
          end
          if (op_r == OP_UNMARK) begin
            refs_nxt = '0;
          end
        end else begin
          mem_rd_en = 1'b1;
          state_nxt = S_EV;
        end
      end
      S_EV: begin
        unique case (op_r) inside
          OP_DEL_UNUSED, OP_DEL_POC: begin
            if (drop) begin
              if (op_r == OP_DEL_POC) begin
                hit_nxt = 1'b1;
              end
              refs_nxt = refs_r - CW'(ent.flags.ref_f);
            end else begin
              mem_wr_en   = 1'b1;
              mem_wr_addr = wr_idx_r[IW-1:0];
              mem_wr_data = ent;
              wr_idx_nxt  = wr_idx_r + 1'b1;
            end
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_RD;
          end
          OP_UNMARK: begin
            mem_wr_en               = 1'b1;
            mem_wr_addr             = idx_r[IW-1:0];
            mem_wr_data             = ent;
            mem_wr_data.flags.ref_f = 1'b0;
            idx_nxt                 = idx_r + 1'b1;
            state_nxt               = S_RD;
          end
          OP_FIND_REF, OP_FIND_LOW, OP_FIND_SHORT, OP_FIND_LONG: begin
            if (find_hit) begin
              res_found_nxt = 1'b1;
              res_hdl_nxt   = ent.hdl;
              res_poc_nxt   = ent.poc;
              status_nxt    = ST_OK;
              state_nxt     = S_FIN;
            end else begin
              idx_nxt   = idx_r + 1'b1;
              state_nxt = S_RD;
            end
          end
          OP_UPDATE: begin
            if (m.hdl_eq) begin
              mem_wr_en         = 1'b1;
              mem_wr_addr       = idx_r[IW-1:0];
              mem_wr_data       = ent;
              mem_wr_data.flags = key_r.flags;
              refs_nxt          = refs_r - CW'(ent.flags.ref_f) + CW'(key_r.flags.ref_f);
              hit_nxt           = 1'b1;
              status_nxt        = ST_OK;
              state_nxt         = S_FIN;
            end else begin
              idx_nxt   = idx_r + 1'b1;
              state_nxt = S_RD;
            end
          end
          OP_LIST: begin
            if (ent.flags.done) begin
              idx_nxt   = idx_r + 1'b1;
              state_nxt = S_RD;
            end else if (cnt_r == LIST_CNT_W'(MAX_RESULTS)) begin
              status_nxt = ST_OK;
              state_nxt  = S_FIN;
            end else if (!res_found_r || out_free) begin
              push          = res_found_r;
              res_found_nxt = 1'b1;
              res_hdl_nxt   = ent.hdl;
              res_poc_nxt   = ent.poc;
              cnt_nxt       = cnt_r + 1'b1;
              idx_nxt       = idx_r + 1'b1;
              state_nxt     = S_RD;
            end
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end
      S_FIN: begin
        if (out_free) begin
          push      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res_hdl_ext = {{OUT_HDL_W{1'b0}}, res_hdl_r};
  assign held_ext    = {{OUT_CNT_W{1'b0}}, held_r};
  assign refs_ext    = {{OUT_CNT_W{1'b0}}, refs_r};
  assign max_ext     = {{CW{1'b0}}, max_pic_r};

  always_comb begin
    res.found             = res_found_r;
    res.found_handle      = res_found_r ? res_hdl_ext[OUT_HDL_W-1:0] : '0;
    res.found_order_count = res_found_r ? res_poc_r : '0;
    res.entry_count       = held_ext[OUT_CNT_W-1:0];
    res.reference_count   = refs_ext[OUT_CNT_W-1:0];
    res.is_full           = (held_ext >= max_ext);
    res.status            = (state_r == S_FIN) ? status_r : ST_OK;
    res.last              = (state_r == S_FIN);
  end

  dpbm_result_reg u_result (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .res      (res),
    .free     (out_free),
    .out_chan (out_chan)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      held_r      <= '0;
      refs_r      <= '0;
      idx_r       <= '0;
      wr_idx_r    <= '0;
      hit_r       <= 1'b0;
      cnt_r       <= '0;
      res_found_r <= 1'b0;
      status_r    <= ST_OK;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      refs_r      <= refs_nxt;
      idx_r       <= idx_nxt;
      wr_idx_r    <= wr_idx_nxt;
      hit_r       <= hit_nxt;
      cnt_r       <= cnt_nxt;
      res_found_r <= res_found_nxt;
      status_r    <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_hdl_r <= res_hdl_nxt;
    res_poc_r <= res_poc_nxt;
    if (in_acc) begin
      op_r  <= in_chan.operation;
      key_r <= in_entry;
    end
  end

  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MAX_PIC);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_pic_r <= MAX_PIC_RESET;
    end else if (cfg_wr) begin
      max_pic_r <= pwdata[OUT_CNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_MAX_PIC) ? {{(APB_DATA_W-OUT_CNT_W){1'b0}}, max_pic_r} : '0;

endmodule
`default_nettype wire

FILE: sv/dpbm_checker.sv
// Port-level checker of the decoded picture buffer manager and its bind.
`timescale 1ns / 1ps
`default_nettype none
module dpbm_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           out_found,
  input logic [dpbm_pkg::OUT_HDL_W-1:0] out_found_handle,
  input logic [dpbm_pkg::POC_W-1:0]     out_found_order_count,
  input logic [dpbm_pkg::ST_W-1:0]      out_status,
  input logic                           out_last
);
  import dpbm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("A stalled result was withdrawn.");

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("A second request was taken while one was in progress.");

  a_empty_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_found_handle == '0 && out_found_order_count == '0)
    else $error("A result without a picture carries picture data.");

  a_drop_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_DROPPED |-> out_last && !out_found)
    else $error("A dropped add did not end with a single empty result.");

endmodule

bind decoded_picture_buffer_manager_unit dpbm_checker u_dpbm_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_valid              (in_chan.valid),
  .in_ready              (in_chan.ready),
  .out_valid             (out_chan.valid),
  .out_ready             (out_chan.ready),
  .out_found             (out_chan.found),
  .out_found_handle      (out_chan.found_handle),
  .out_found_order_count (out_chan.found_order_count),
  .out_status            (out_chan.status),
  .out_last              (out_chan.last)
);
`default_nettype wire

FILE: bench/decoded_picture_buffer_manager_unit_tb.sv
// Self-checking testbench for the decoded picture buffer manager: directed script, random traffic, APB setup.
`timescale 1ns / 1ps
module decoded_picture_buffer_manager_unit_tb;
  import dpbm_pkg::*;

  localparam int DEPTH        = 16;
  localparam int HANDLE_WIDTH = 8;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 45;
  localparam int SETTLE       = 60;
  localparam int CYCLE_LIMIT  = 1_500_000;

  localparam logic [OP_W-1:0] OP_SPARE_LO = 4'd13;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 4'd15;

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic [IN_HDL_W-1:0]     handle;
    logic signed [POC_W-1:0] poc;
    logic [LOW_W-1:0]        low;
    logic                    is_ref;
    logic                    is_lterm;
    logic                    is_done;
  } request_t;

  typedef struct packed {
    logic [IN_HDL_W-1:0] handle;
    logic [POC_W-1:0]    poc;
    logic [LOW_W-1:0]    low;
    flags_t              flags;
  } picture_t;

  typedef struct {
    request_t q;
    bit       typed;
    result_t  want;
    int       reps;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel, penable, pwrite, pready;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata, prdata;

  dpbm_in_if  in_chan();
  dpbm_out_if out_chan();

  decoded_picture_buffer_manager_unit #(
    .DEPTH(DEPTH),
    .HANDLE_WIDTH(HANDLE_WIDTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_chan),
    .out_chan(out_chan),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the picture store and its setting.
  picture_t             dpb_store [DEPTH];
  int                   held = 0;
  logic [OUT_CNT_W-1:0] max_pictures = MAX_PIC_RESET;

  result_t     dpb_answers_new [$];
  result_t     dpb_answers_due [$];
  script_row_t script_rows [$];

  bit calm = 1'b0;
  int stall_left = 0;
  int cycle_count = 0;
  int mismatches = 0;
  int requests_sent = 0;
  int results_seen = 0;
  int reports_seen = 0;
  int misses_seen = 0;
  int drops_seen = 0;
  int settings_seen = 1;

  function automatic logic [OUT_CNT_W-1:0] reference_total();
    int n = 0;
    for (int i = 0; i < held; i++)
      if (dpb_store[i].flags.ref_f) n++;
    return OUT_CNT_W'(n);
  endfunction

  function automatic result_t buffer_answer(bit hit, int idx, logic [ST_W-1:0] st, bit fin);
    result_t r;
    r.found             = hit;
    r.found_handle      = hit ? OUT_HDL_W'(dpb_store[idx].handle) : '0;
    r.found_order_count = hit ? dpb_store[idx].poc : '0;
    r.entry_count       = OUT_CNT_W'(held);
    r.reference_count   = reference_total();
    r.is_full           = (held >= max_pictures);
    r.status            = st;
    r.last              = fin;
    return r;
  endfunction

  function automatic void drop_entry(int k);
    for (int j = k; j < held - 1; j++) dpb_store[j] = dpb_store[j + 1];
    held--;
  endfunction

  // Applies one request to the shadow store and queues the answers it produces.
  function automatic void apply_dpb_request(request_t q);
    int hit_at = -1;
    int shown = 0;
    int i = 0;
    bit m;
    case (q.op)
      OP_ADD: begin
        if (held >= DEPTH) begin
          dpb_answers_new.push_back(buffer_answer(0, 0, ST_DROPPED, 1));
        end else begin
          dpb_store[held].handle = q.handle;
          dpb_store[held].poc    = q.poc;
          dpb_store[held].low    = q.low;
          dpb_store[held].flags  = '{ref_f: q.is_ref, lterm: q.is_lterm, done: q.is_done};
          held++;
          dpb_answers_new.push_back(buffer_answer(0, 0, ST_OK, 1));
        end
      end
      OP_CLEAR: begin
        held = 0;
        dpb_answers_new.push_back(buffer_answer(0, 0, ST_OK, 1));
      end
      OP_DEL_UNUSED: begin
        while (i < held) begin
          if (dpb_store[i].flags.done && !dpb_store[i].flags.ref_f) drop_entry(i);
          else i++;
        end
        dpb_answers_new.push_back(buffer_answer(0, 0, ST_OK, 1));
      end
      OP_DEL_POC: begin
        for (i = 0; i < held; i++)
          if (hit_at < 0 && dpb_store[i].poc == q.poc) hit_at = i;
        if (hit_at >= 0) drop_entry(hit_at);
        dpb_answers_new.push_back(buffer_answer(0, 0, hit_at >= 0 ? ST_OK : ST_NOT_FOUND, 1));
      end
      OP_UNMARK: begin
        for (i = 0; i < held; i++) dpb_store[i].flags.ref_f = 1'b0;
        dpb_answers_new.push_back(buffer_answer(0, 0, ST_OK, 1));
      end
      OP_FIND_REF, OP_FIND_LOW, OP_FIND_SHORT, OP_FIND_LONG: begin
        for (i = 0; i < held; i++) begin
          if (q.op == OP_FIND_LOW)
            m = dpb_store[i].low == q.low;
          else
            m = dpb_store[i].poc == q.poc &&
                (q.op == OP_FIND_REF ||
                 (q.op == OP_FIND_SHORT && !dpb_store[i].flags.lterm) ||
                 (q.op == OP_FIND_LONG && dpb_store[i].flags.lterm));
          if (hit_at < 0 && dpb_store[i].flags.ref_f && m) hit_at = i;
        end
        if (hit_at >= 0) dpb_answers_new.push_back(buffer_answer(1, hit_at, ST_OK, 1));
        else dpb_answers_new.push_back(buffer_answer(0, 0, ST_NOT_FOUND, 1));
      end
      OP_LIST: begin
        for (i = 0; i < held; i++) begin
          if (!dpb_store[i].flags.done && shown < MAX_RESULTS) begin
            dpb_answers_new.push_back(buffer_answer(1, i, ST_OK, 0));
            shown++;
          end
        end
        if (shown == 0) dpb_answers_new.push_back(buffer_answer(0, 0, ST_NOT_FOUND, 1));
        else dpb_answers_new[dpb_answers_new.size() - 1].last = 1'b1;
      end
      OP_UPDATE: begin
        for (i = 0; i < held; i++)
          if (hit_at < 0 && dpb_store[i].handle == q.handle) hit_at = i;
        if (hit_at >= 0)
          dpb_store[hit_at].flags = '{ref_f: q.is_ref, lterm: q.is_lterm, done: q.is_done};
        dpb_answers_new.push_back(buffer_answer(0, 0, hit_at >= 0 ? ST_OK : ST_NOT_FOUND, 1));
      end
      default: begin
        dpb_answers_new.push_back(buffer_answer(0, 0, ST_OK, 1));
      end
    endcase
  endfunction

  function automatic request_t req(logic [OP_W-1:0] op, logic [IN_HDL_W-1:0] h,
                                   logic [POC_W-1:0] poc, logic [LOW_W-1:0] low,
                                   logic r, logic lt, logic dn);
    request_t q;
    q = '{op: op, handle: h, poc: poc, low: low, is_ref: r, is_lterm: lt, is_done: dn};
    return q;
  endfunction

  function automatic result_t plain_answer(int entries, int refs, bit full,
                                           logic [ST_W-1:0] st);
    result_t r;
    r = '0;
    r.entry_count     = OUT_CNT_W'(entries);
    r.reference_count = OUT_CNT_W'(refs);
    r.is_full         = full;
    r.status          = st;
    r.last            = 1'b1;
    return r;
  endfunction

  function automatic void add_row(request_t q, bit typed, result_t want, int reps);
    script_row_t row;
    row = '{q: q, typed: typed, want: want, reps: reps};
    script_rows.push_back(row);
  endfunction

  function automatic int gap_length();
    int pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(1, 2);
    if (pick < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 40);
  endfunction

  function automatic int sender_gap();
    if (calm || $urandom_range(0, 99) >= 35) return 0;
    return gap_length();
  endfunction

  // Mostly requests aimed at pictures that are held, with some blind ones mixed in.
  function automatic request_t random_request();
    request_t q;
    int pick = $urandom_range(0, 99);
    int k = (held > 0) ? $urandom_range(0, held - 1) : 0;
    bit reuse = (held > 0) && ($urandom_range(0, 3) != 0);
    q.handle = $urandom_range(0, 1) ? IN_HDL_W'($urandom_range(0, 7)) : IN_HDL_W'($urandom);
    q.poc    = $urandom_range(0, 1) ? POC_W'($urandom_range(0, 15)) - 8 : POC_W'($urandom);
    q.low    = $urandom_range(0, 1) ? LOW_W'($urandom_range(0, 7)) : LOW_W'($urandom);
    {q.is_ref, q.is_lterm, q.is_done} = 3'($urandom);
    if (pick < 30) q.op = OP_ADD;
    else if (pick < 38) q.op = OP_FIND_REF;
    else if (pick < 44) q.op = OP_FIND_LOW;
    else if (pick < 50) q.op = OP_FIND_SHORT;
    else if (pick < 56) q.op = OP_FIND_LONG;
    else if (pick < 62) q.op = OP_UPDATE;
    else if (pick < 68) q.op = OP_DEL_POC;
    else if (pick < 73) q.op = OP_LIST;
    else if (pick < 78) q.op = OP_DEL_UNUSED;
    else if (pick < 82) q.op = OP_COUNT_REF;
    else if (pick < 85) q.op = OP_UNMARK;
    else if (pick < 88) q.op = OP_STATUS;
    else if (pick < 90) q.op = OP_CLEAR;
    else if (pick < 93) q.op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    else q.op = OP_W'($urandom_range(0, 15));
    if (reuse && pick < 93) begin
      q.handle = dpb_store[k].handle;
      q.poc    = dpb_store[k].poc;
      q.low    = dpb_store[k].low;
    end
    return q;
  endfunction

  task automatic send_request(request_t q, bit typed, result_t want, int gap);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid           <= 1'b1;
    in_chan.operation       <= q.op;
    in_chan.picture_handle  <= q.handle;
    in_chan.order_count     <= q.poc;
    in_chan.order_count_low <= q.low;
    in_chan.is_reference    <= q.is_ref;
    in_chan.is_long_term    <= q.is_lterm;
    in_chan.is_output_done  <= q.is_done;
    do @(posedge clk); while (!in_chan.ready);
    dpb_answers_new.delete();
    apply_dpb_request(q);
    if (typed) dpb_answers_due.push_back(want);
    else foreach (dpb_answers_new[i]) dpb_answers_due.push_back(dpb_answers_new[i]);
    requests_sent++;
  endtask

  task automatic hold_until_drained();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (dpb_answers_due.size() != 0);
  endtask

  task automatic write_max_pictures(logic [OUT_CNT_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(4 * int'(REG_MAX_PIC));
    pwdata  <= APB_DATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    max_pictures = v;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== APB_DATA_W'(v)) begin
      $error("max_pictures readback: expected %0h, got %0h", v, prdata);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (calm) begin
      stall_left = 0;
      out_chan.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_chan.ready <= 1'b0;
    end else if ($urandom_range(0, 99) < 20) begin
      stall_left = gap_length() - 1;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    result_t got, want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got.found             = out_chan.found;
      got.found_handle      = out_chan.found_handle;
      got.found_order_count = out_chan.found_order_count;
      got.entry_count       = out_chan.entry_count;
      got.reference_count   = out_chan.reference_count;
      got.is_full           = out_chan.is_full;
      got.status            = out_chan.status;
      got.last              = out_chan.last;
      results_seen++;
      if (got.found) reports_seen++;
      if (got.status == ST_NOT_FOUND) misses_seen++;
      if (got.status == ST_DROPPED) drops_seen++;
      if (dpb_answers_due.size() == 0) begin
        $error("result arrived with no request pending");
        mismatches++;
      end else begin
        want = dpb_answers_due.pop_front();
        check_field("found", want.found, got.found);
        check_field("found_handle", want.found_handle, got.found_handle);
        check_field("found_order_count", want.found_order_count, got.found_order_count);
        check_field("entry_count", want.entry_count, got.entry_count);
        check_field("reference_count", want.reference_count, got.reference_count);
        check_field("is_full", want.is_full, got.is_full);
        check_field("status", want.status, got.status);
        check_field("last", want.last, got.last);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, dpb_answers_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    request_t             q;
    logic [OUT_CNT_W-1:0] limits [PHASES];
    in_chan.valid           = 1'b0;
    in_chan.operation       = OP_STATUS;
    in_chan.picture_handle  = '0;
    in_chan.order_count     = '0;
    in_chan.order_count_low = '0;
    in_chan.is_reference    = 1'b0;
    in_chan.is_long_term    = 1'b0;
    in_chan.is_output_done  = 1'b0;
    out_chan.ready          = 1'b0;
    psel                    = 1'b0;
    penable                 = 1'b0;
    pwrite                  = 1'b0;
    paddr                   = '0;
    pwdata                  = '0;
    limits = '{5'd0, 5'd31, OUT_CNT_W'($urandom_range(2, 15)), 5'd1,
               OUT_CNT_W'($urandom_range(2, 15)), MAX_PIC_RESET};

    add_row(req(OP_STATUS, 8'h00, 32'h0, 16'h0, 0, 0, 0), 1,
            plain_answer(0, 0, 0, ST_OK), 1);
    add_row(req(OP_LIST, 8'h00, 32'h0, 16'h0, 0, 0, 0), 1,
            plain_answer(0, 0, 0, ST_NOT_FOUND), 1);
    add_row(req(OP_FIND_REF, 8'h00, 32'h0, 16'h0, 0, 0, 0), 1,
            plain_answer(0, 0, 0, ST_NOT_FOUND), 1);
    add_row(req(OP_DEL_POC, 8'h00, 32'h0, 16'h0, 0, 0, 0), 1,
            plain_answer(0, 0, 0, ST_NOT_FOUND), 1);
    add_row(req(OP_UPDATE, 8'h00, 32'h0, 16'h0, 1, 1, 1), 1,
            plain_answer(0, 0, 0, ST_NOT_FOUND), 1);
    add_row(req(OP_ADD, 8'hFF, 32'h7FFF_FFFF, 16'hFFFF, 1, 1, 0), 1,
            plain_answer(1, 1, 0, ST_OK), 1);
    add_row(req(OP_ADD, 8'h00, 32'h8000_0000, 16'h0000, 1, 0, 0), 1,
            plain_answer(2, 2, 0, ST_OK), 1);
    add_row(req(OP_ADD, 8'h5A, 32'hFFFF_FFFF, 16'h1234, 0, 0, 1), 1,
            plain_answer(3, 2, 0, ST_OK), 1);
    add_row(req(OP_FIND_REF, 8'h00, 32'h7FFF_FFFF, 16'h0, 0, 0, 0), 0, '0, 1);
    add_row(req(OP_FIND_LOW, 8'h00, 32'h0, 16'h0000, 0, 0, 0), 0, '0, 1);
    add_row(req(OP_FIND_LOW, 8'h00, 32'h0, 16'h1234, 0, 0, 0), 0, '0, 1);
    add_row(req(OP_FIND_SHORT, 8'h00, 32'h8000_0000, 16'h0, 0, 0, 0), 0, '0, 1);
    add_row(req(OP_FIND_LONG, 8'h00, 32'h8000_0000, 16'h0, 0, 0, 0), 0, '0, 1);
    add_row(req(OP_FIND_LONG, 8'h00, 32'h7FFF_FFFF, 16'h0, 0, 0, 0), 0, '0, 1);
    add_row(req(OP_COUNT_REF, 8'h00, 32'h0, 16'h0, 0, 0, 0), 1,
            plain_answer(3, 2, 0, ST_OK), 1);
    add_row(req(OP_LIST, 8'h00, 32'h0, 16'h0, 0, 0, 0), 0, '0, 1);
    add_row(req(OP_UPDATE, 8'h5A, 32'h0, 16'h0, 1, 1, 0), 0, '0, 1);
    add_row(req(OP_SPARE_LO, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 1, 1, 1), 0, '0, 1);
    add_row(req(OP_SPARE_HI, 8'h00, 32'h0, 16'h0, 0, 0, 0), 0, '0, 1);
    add_row(req(OP_UNMARK, 8'h00, 32'h0, 16'h0, 0, 0, 0), 1,
            plain_answer(3, 0, 0, ST_OK), 1);
    add_row(req(OP_UPDATE, 8'hFF, 32'h0, 16'h0, 0, 0, 1), 0, '0, 1);
    add_row(req(OP_DEL_UNUSED, 8'h00, 32'h0, 16'h0, 0, 0, 0), 0, '0, 1);
    add_row(req(OP_DEL_POC, 8'h00, 32'hFFFF_FFFF, 16'h0, 0, 0, 0), 0, '0, 1);
    add_row(req(OP_CLEAR, 8'h00, 32'h0, 16'h0, 0, 0, 0), 1,
            plain_answer(0, 0, 0, ST_OK), 1);
    // Fill the store to DEPTH, then one add too many must be dropped.
    add_row(req(OP_ADD, 8'h10, 32'd100, 16'h0100, 0, 0, 0), 0, '0, DEPTH);
    add_row(req(OP_ADD, 8'hEE, 32'd7, 16'h0007, 1, 0, 0), 1,
            plain_answer(DEPTH, DEPTH / 2, 1, ST_DROPPED), 1);
    add_row(req(OP_LIST, 8'h00, 32'h0, 16'h0, 0, 0, 0), 0, '0, 1);
    add_row(req(OP_CLEAR, 8'h00, 32'h0, 16'h0, 0, 0, 0), 0, '0, 1);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script_rows[r]) begin
      for (int k = 0; k < script_rows[r].reps; k++) begin
        q = script_rows[r].q;
        if (script_rows[r].reps > 1) begin
          q.handle = q.handle + IN_HDL_W'(k);
          q.poc    = q.poc + k;
          q.low    = q.low + LOW_W'(k);
          q.is_ref = k[0];
        end
        send_request(q, script_rows[r].typed, script_rows[r].want, sender_gap());
      end
    end
    hold_until_drained();

    for (int p = 0; p < PHASES; p++) begin
      calm <= (p == 3);
      write_max_pictures(limits[p]);
      settings_seen++;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2 && p % 2 == 0) hold_until_drained();
        send_request(random_request(), 1'b0, '0, sender_gap());
      end
      hold_until_drained();
    end
    repeat (SETTLE) @(posedge clk);

    $display("Covered %0d requests and %0d results over %0d max_pictures settings.",
             requests_sent, results_seen, settings_seen);
    $display("Seen: %0d pictures reported, %0d not found, %0d adds dropped, %0d mismatches.",
             reports_seen, misses_seen, drops_seen, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: decoded_picture_buffer_manager_unit.f
sv/dpbm_pkg.sv
sv/dpbm_ifs.sv
sv/dpbm_store.sv
sv/dpbm_match.sv
sv/dpbm_result_reg.sv
sv/decoded_picture_buffer_manager_unit.sv
sv/dpbm_checker.sv
bench/decoded_picture_buffer_manager_unit_tb.sv
